[hdl/rnncf_pkg.sv]
// rnncf_pkg: shared constants, types and the tanh lookup table for the RNN cell core.
// No dependencies.
package rnncf_pkg;

    localparam int UNITS        = 16;
    localparam int FEATURES     = 16;
    localparam int TANH_ENTRIES = 1024;

    localparam int CNT_W   = $clog2(UNITS + 1);
    localparam int IW_DEPTH = FEATURES * UNITS;
    localparam int RW_DEPTH = UNITS * UNITS;
    localparam int IW_AW   = (IW_DEPTH > 1) ? $clog2(IW_DEPTH) : 1;
    localparam int RW_AW   = (RW_DEPTH > 1) ? $clog2(RW_DEPTH) : 1;
    localparam int TIDX_W  = $clog2(TANH_ENTRIES);
    localparam int ACC_W   = 40;
    localparam int RSUM_W  = 40;
    localparam int SUM_W   = 42;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        MODE_IW   = 3'd0,
        MODE_RW   = 3'd1,
        MODE_B1   = 3'd2,
        MODE_B2   = 3'd3,
        MODE_FEAT = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CFG_RET_ALL  = 3'd0,
        CFG_BIAS     = 3'd1,
        CFG_UNITS    = 3'd2,
        CFG_FEATURES = 3'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BIAS_NONE   = 2'd0,
        BIAS_SINGLE = 2'd1,
        BIAS_DUAL   = 2'd2
    } bias_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEAT,
        ST_RECUR,
        ST_FIN1,
        ST_FIN2,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic shift_unit;
        logic shift_prev;
        logic commit;
        logic clear_acc;
    } cell_ctrl_t;

    typedef logic signed [15:0] tanh_rom_t [TANH_ENTRIES];

    // shift-subtract quotient, used only while the table is built
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
        longint unsigned quo, rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], a[i]};
            if (rem >= b)
            begin
                rem    = rem - b;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic tanh_rom_t build_tanh();
        tanh_rom_t t;
        longint m;
        longint unsigned mag, u, term, sum, y, num, den, q;
        for (int k = 0; k < TANH_ENTRIES; k++)
        begin
            m    = longint'(2 * k + 1) - longint'(TANH_ENTRIES);
            mag  = longint'(m < 0 ? -m : m);
            u    = (mag << 29) >> TIDX_W;
            term = 64'd1 << 30;
            sum  = 64'd1 << 30;
            for (int n = 1; n <= 16; n++)
            begin
                term = udiv64((term * u) >> 30, longint'(n));
                if ((n & 1) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            y = sum;
            for (int n = 0; n < 5; n++)
                y = (y * y) >> 30;
            if (y > (64'd1 << 30))
                y = 64'd1 << 30;
            num = ((64'd1 << 30) - y) * 8192;
            den = (64'd1 << 30) + y;
            q   = udiv64(num + den, 2 * den);
            t[k] = (m < 0) ? -16'(q) : 16'(q);
        end
        return t;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh();

endpackage

[hdl/rnncf_ram.sv]
// rnncf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rnncf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/rnncf_cell.sv]
// rnncf_cell: one hidden-unit cell: accumulator, biases, new and previous hidden value.
// Depends on rnncf_pkg. Cells form two rotating rings (unit ring and previous-hidden ring).
module rnncf_cell
    import rnncf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  logic                    commit_en,
    input  logic                    b1_we,
    input  logic                    b2_we,
    input  logic signed [15:0]      wdata,
    input  logic signed [ACC_W-1:0] acc_in,
    input  logic signed [15:0]      b1_in,
    input  logic signed [15:0]      b2_in,
    input  logic signed [15:0]      fresh_in,
    input  logic signed [15:0]      prev_in,
    output logic signed [ACC_W-1:0] acc,
    output logic signed [15:0]      b1,
    output logic signed [15:0]      b2,
    output logic signed [15:0]      fresh,
    output logic signed [15:0]      prev
);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [15:0]      prev_reg, prev_next;
    logic signed [15:0]      b1_reg, b1_next, b2_reg, b2_next, fresh_reg, fresh_next;

    always_comb
    begin
        acc_next   = acc_reg;
        prev_next  = prev_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        fresh_next = fresh_reg;
        if (ctrl.shift_unit)
        begin
            acc_next   = acc_in;
            b1_next    = b1_in;
            b2_next    = b2_in;
            fresh_next = fresh_in;
        end
        if (ctrl.shift_prev)
            prev_next = prev_in;
        if (ctrl.commit && commit_en)
            prev_next = fresh_reg;
        if (ctrl.clear_acc)
            acc_next = '0;
        if (b1_we)
            b1_next = wdata;
        if (b2_we)
            b2_next = wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        fresh_reg <= fresh_next;
    end

    assign acc   = acc_reg;
    assign b1    = b1_reg;
    assign b2    = b2_reg;
    assign fresh = fresh_reg;
    assign prev  = prev_reg;

endmodule

[hdl/rnn_cell_forward_core.sv]
// rnn_cell_forward_core: Elman RNN cell (tanh) inference core in Q4.12.
// Depends on rnncf_pkg, rnncf_ram, rnncf_cell.
//
// Input channel (in_valid/in_stall) carries load items (weights, biases) and
// feature samples. A load does not raise in_stall. A feature sample holds
// in_stall while one multiply-accumulate per unit runs as the unit ring rotates past the
// head cell, fed by the input weight RAM read port. A sample with step_last
// then runs, per unit, a recurrent MAC while the previous-hidden ring rotates,
// then rounding and the tanh lookup; an emitted vector then holds in_stall
// through the emission, which waits while the output stalls.
// in_stall is high while an item is in work.
// When emitted, the hidden vector leaves as nu transfers on the
// output channel (out_valid/out_stall), unit 0 first, last set on the final
// one; a held output stalls the emission only. The output register lets the
// next item be taken while the final result waits.
// Configuration writes (cfg_valid/cfg_ready, always ready) must be made while idle; the core does not check this.
// Reset clears accumulators and previous hidden state and loads the register
// defaults; weight and bias stores are undefined until written.
module rnn_cell_forward_core
    import rnncf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic [5:0]         row,
    input  logic [5:0]         column,
    input  logic signed [15:0] value,
    input  logic               seq_start,
    input  logic               step_last,
    input  logic               seq_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         unit_index,
    output logic signed [15:0] hidden_value,
    output logic               last
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, ucnt_reg, ucnt_next;
    logic       ret_all_reg;
    logic [1:0] bias_mode_reg;
    logic [6:0] units_reg, feats_reg;
    logic signed [15:0] val_reg;
    logic [5:0] row_reg;
    logic       seq_start_reg, step_last_reg, seq_last_reg;
    logic signed [RSUM_W-1:0] rsum_reg, rsum_next;
    logic signed [15:0] sat_reg, sat_next;
    logic       out_valid_reg, out_valid_next;
    logic [5:0] unit_index_reg, unit_index_next;
    logic signed [15:0] hidden_reg, hidden_next;
    logic       last_reg, last_next;

    logic [6:0] nu7, nf7;
    logic [CNT_W-1:0] nu;
    logic in_acc;
    cell_ctrl_t ctrl;

    logic signed [ACC_W-1:0] acc_q [UNITS];
    logic signed [15:0] b1_q [UNITS], b2_q [UNITS], fresh_q [UNITS], prev_q [UNITS];
    logic signed [ACC_W-1:0] acc_head_in;
    logic signed [15:0] fresh_head_in;

    logic iw_we, rw_we;
    logic [IW_AW-1:0] iw_waddr, iw_raddr;
    logic [RW_AW-1:0] rw_waddr, rw_raddr;
    logic signed [15:0] iw_rdata, rw_rdata;

    logic signed [31:0] mprod, rprod;
    logic signed [ACC_W:0] mac_sum;
    logic signed [ACC_W-1:0] mac_sat;
    logic signed [16:0] bias_sum;
    logic signed [SUM_W-1:0] step_sum, step_round;
    logic signed [15:0] tanh_val;
    logic [15:0] biased;
    logic [CNT_W-1:0] cnt_m1;
    logic out_free;

    assign nu7 = (units_reg == 7'd0) ? 7'd1 :
                 (units_reg > 7'(UNITS)) ? 7'(UNITS) : units_reg;
    assign nf7 = (feats_reg == 7'd0) ? 7'd1 :
                 (feats_reg > 7'(FEATURES)) ? 7'(FEATURES) : feats_reg;
    assign nu  = CNT_W'(nu7);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ret_all_reg   <= 1'b0;
            bias_mode_reg <= BIAS_SINGLE;
            units_reg     <= 7'd16;
            feats_reg     <= 7'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RET_ALL:  ret_all_reg   <= cfg_data[0];
                CFG_BIAS:     bias_mode_reg <= cfg_data[1:0];
                CFG_UNITS:    units_reg     <= cfg_data;
                CFG_FEATURES: feats_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // weight stores
    assign iw_we    = in_acc && (mode == MODE_IW) && (row < FEATURES) && (column < UNITS);
    assign rw_we    = in_acc && (mode == MODE_RW) && (row < UNITS) && (column < UNITS);
    assign iw_waddr = IW_AW'(row * UNITS + column);
    assign rw_waddr = RW_AW'(row * UNITS + column);
    assign iw_raddr = IW_AW'(row_reg * UNITS + cnt_reg);
    assign rw_raddr = RW_AW'(cnt_reg * UNITS + ucnt_reg);

    rnncf_ram #(.WIDTH(16), .DEPTH(IW_DEPTH)) u_iw_ram (
        .clk   (clk),
        .we    (iw_we),
        .waddr (iw_waddr),
        .wdata (value),
        .raddr (iw_raddr),
        .rdata (iw_rdata)
    );

    rnncf_ram #(.WIDTH(16), .DEPTH(RW_DEPTH)) u_rw_ram (
        .clk   (clk),
        .we    (rw_we),
        .waddr (rw_waddr),
        .wdata (value),
        .raddr (rw_raddr),
        .rdata (rw_rdata)
    );

    // datapath at the head cell
    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign mprod   = val_reg * iw_rdata;
    assign mac_sum = (ACC_W+1)'(acc_q[0]) + (ACC_W+1)'(mprod);
    assign mac_sat = (mac_sum > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX :
                     (mac_sum < (ACC_W+1)'(ACC_MIN)) ? ACC_MIN : mac_sum[ACC_W-1:0];
    assign rprod   = prev_q[0] * rw_rdata;

    always_comb
    begin
        case (bias_mode_reg)
            BIAS_SINGLE: bias_sum = 17'(b1_q[0]);
            BIAS_DUAL:   bias_sum = 17'(b1_q[0]) + 17'(b2_q[0]);
            default:     bias_sum = '0;
        endcase
    end

    assign step_sum   = SUM_W'(acc_q[0]) + (SUM_W'(bias_sum) <<< 12) + SUM_W'(rsum_reg);
    assign step_round = (step_sum + SUM_W'(2048)) >>> 12;
    assign biased     = {~sat_reg[15], sat_reg[14:0]};
    assign tanh_val   = TANH_ROM[biased[15 -: TIDX_W]];
    assign out_free   = !out_valid_reg || !out_stall;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ucnt_next       = ucnt_reg;
        rsum_next       = rsum_reg;
        sat_next        = sat_reg;
        ctrl            = '0;
        acc_head_in     = acc_q[0];
        fresh_head_in   = fresh_q[0];
        out_valid_next  = out_valid_reg && out_stall;
        unit_index_next = unit_index_reg;
        hidden_next     = hidden_reg;
        last_next       = last_reg;
        if (step_round > SUM_W'(32767))
            sat_next = 16'sh7FFF;
        else if (step_round < -SUM_W'(32768))
            sat_next = 16'sh8000;
        else
            sat_next = step_round[15:0];
        if (state_reg != ST_FIN1)
            sat_next = sat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && mode == MODE_FEAT)
                begin
                    cnt_next   = '0;
                    state_next = ST_FEAT;
                end
            end
            ST_FEAT:
            begin
                if (cnt_reg != '0)
                begin
                    ctrl.shift_unit = 1'b1;
                    if (cnt_reg <= nu && 7'(row_reg) < nf7)
                        acc_head_in = mac_sat;
                end
                if (cnt_reg == CNT_W'(UNITS))
                begin
                    cnt_next   = '0;
                    ucnt_next  = '0;
                    state_next = step_last_reg ? ST_RECUR : ST_IDLE;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_RECUR:
            begin
                if (cnt_reg == '0)
                    rsum_next = '0;
                else
                begin
                    ctrl.shift_prev = 1'b1;
                    if (cnt_m1 < nu && !seq_start_reg)
                        rsum_next = rsum_reg + RSUM_W'(rprod);
                end
                if (cnt_reg == CNT_W'(UNITS))
                    state_next = ST_FIN1;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_FIN1:
            begin
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                ctrl.shift_unit = 1'b1;
                fresh_head_in   = tanh_val;
                cnt_next        = '0;
                if (ucnt_reg == CNT_W'(UNITS - 1))
                    state_next = ST_COMMIT;
                else
                begin
                    ucnt_next  = ucnt_reg + CNT_W'(1);
                    state_next = ST_RECUR;
                end
            end
            ST_COMMIT:
            begin
                ctrl.commit    = 1'b1;
                ctrl.clear_acc = 1'b1;
                cnt_next       = '0;
                state_next     = (ret_all_reg || seq_last_reg) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (cnt_reg >= nu || out_free)
                begin
                    ctrl.shift_unit = 1'b1;
                    if (cnt_reg < nu)
                    begin
                        out_valid_next  = 1'b1;
                        unit_index_next = 6'(cnt_reg);
                        hidden_next     = fresh_q[0];
                        last_next       = (cnt_reg + CNT_W'(1) == nu);
                    end
                    if (cnt_reg == CNT_W'(UNITS - 1))
                        state_next = ST_IDLE;
                    else
                        cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ucnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ucnt_reg      <= ucnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsum_reg       <= rsum_next;
        sat_reg        <= sat_next;
        unit_index_reg <= unit_index_next;
        hidden_reg     <= hidden_next;
        last_reg       <= last_next;
        if (in_acc && mode == MODE_FEAT)
        begin
            val_reg       <= value;
            row_reg       <= row;
            seq_start_reg <= seq_start;
            step_last_reg <= step_last;
            seq_last_reg  <= seq_last;
        end
    end

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < UNITS; gi++)
        begin : g_cell
            localparam int NX = (gi + 1) % UNITS;
            logic b1_we_c, b2_we_c;
            assign b1_we_c = in_acc && (mode == MODE_B1) && (column == 6'(gi));
            assign b2_we_c = in_acc && (mode == MODE_B2) && (column == 6'(gi));
            rnncf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .commit_en (CNT_W'(gi) < nu),
                .b1_we     (b1_we_c),
                .b2_we     (b2_we_c),
                .wdata     (value),
                .acc_in    ((gi == UNITS - 1) ? acc_head_in : acc_q[NX]),
                .b1_in     (b1_q[NX]),
                .b2_in     (b2_q[NX]),
                .fresh_in  ((gi == UNITS - 1) ? fresh_head_in : fresh_q[NX]),
                .prev_in   (prev_q[NX]),
                .acc       (acc_q[gi]),
                .b1        (b1_q[gi]),
                .b2        (b2_q[gi]),
                .fresh     (fresh_q[gi]),
                .prev      (prev_q[gi])
            );
        end
    endgenerate

    assign out_valid    = out_valid_reg;
    assign unit_index   = unit_index_reg;
    assign hidden_value = hidden_reg;
    assign last         = last_reg;

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_EMIT))
        else $error("output transfer started outside emission");

    a_last_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last && state_reg == ST_EMIT) |-> (CNT_W'(unit_index) + CNT_W'(1) == nu))
        else $error("last flag on wrong unit");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && mode == MODE_FEAT) |=> in_stall)
        else $error("feature sample did not start work");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(UNITS) && ucnt_reg < CNT_W'(UNITS))
        else $error("sequencer counter out of range");

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for rnn_cell_forward_core (Elman tanh cell, Q4.12).
// Depends on rnncf_pkg and the core. Items are checked against a cycle-free predictor
// of the cell, with random idling on both channels and several register settings.
module tb_top;
    import rnncf_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int LOAD_N         = 4;
    localparam logic [2:0] MODE_SPARE = 3'd5;

    typedef struct {
        logic [2:0]         mode;
        logic [5:0]         row;
        logic [5:0]         column;
        logic signed [15:0] value;
        logic               seq_start;
        logic               step_last;
        logic               seq_last;
    } item_t;

    typedef struct {
        logic [5:0]         unit_index;
        logic signed [15:0] hidden_value;
        logic               last;
    } hidden_t;

    typedef struct {
        item_t  it;
        bit     typed;
        int     hidden;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [6:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         mode;
    logic [5:0]         row;
    logic [5:0]         column;
    logic signed [15:0] value;
    logic               seq_start;
    logic               step_last;
    logic               seq_last;
    logic               out_valid;
    logic               out_stall;
    logic [5:0]         unit_index;
    logic signed [15:0] hidden_value;
    logic               last;

    rnn_cell_forward_core dut (.*);

    // predictor state
    logic signed [15:0] iw_mem [FEATURES*UNITS];
    logic signed [15:0] rw_mem [UNITS*UNITS];
    logic signed [15:0] bias1 [UNITS];
    logic signed [15:0] bias2 [UNITS];
    longint             acc [UNITS];
    logic signed [15:0] prev_h [UNITS];
    logic signed [15:0] tanh_lut [TANH_ENTRIES];
    logic               ret_all;
    logic [1:0]         bias_sel;
    logic [6:0]         units_cfg;
    logic [6:0]         feats_cfg;

    hidden_t hidden_q [$];
    int      mismatches;
    int      idle_cycles;
    bit      quiet;
    int      rand_items;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic fill_tanh_lut();
        longint m;
        longint unsigned mag, u, term, sum, y, num, den, q;
        for (int k = 0; k < TANH_ENTRIES; k++)
        begin
            m   = 2 * k + 1 - TANH_ENTRIES;
            mag = (m < 0) ? -m : m;
            u   = (mag << 29) / TANH_ENTRIES;
            term = 64'd1 << 30;
            sum  = term;
            for (int n = 1; n <= 16; n++)
            begin
                term = ((term * u) >> 30) / n;
                sum  = (n & 1) ? sum - term : sum + term;
            end
            y = sum;
            repeat (5) y = (y * y) >> 30;
            if (y > (64'd1 << 30))
                y = 64'd1 << 30;
            num = ((64'd1 << 30) - y) * 8192;
            den = (64'd1 << 30) + y;
            q   = (num + den) / (2 * den);
            tanh_lut[k] = (m < 0) ? -16'(q) : 16'(q);
        end
    endtask

    function automatic int eff_count(logic [6:0] r, int lim);
        if (r == 0)
            return 1;
        return (r > lim) ? lim : int'(r);
    endfunction

    task automatic advance_cell(item_t it);
        int      nu;
        int      nf;
        longint  s;
        longint  acc_hi;
        int      idx;
        logic signed [15:0] fresh [UNITS];
        hidden_t h;
        nu = eff_count(units_cfg, UNITS);
        nf = eff_count(feats_cfg, FEATURES);
        acc_hi = (64'sd1 <<< 39) - 1;
        case (it.mode)
            MODE_IW:
                if (it.row < FEATURES && it.column < UNITS)
                    iw_mem[it.row*UNITS + it.column] = it.value;
            MODE_RW:
                if (it.row < UNITS && it.column < UNITS)
                    rw_mem[it.row*UNITS + it.column] = it.value;
            MODE_B1:
                if (it.column < UNITS)
                    bias1[it.column] = it.value;
            MODE_B2:
                if (it.column < UNITS)
                    bias2[it.column] = it.value;
            MODE_FEAT:
            begin
                if (it.row < nf)
                    for (int k = 0; k < nu; k++)
                    begin
                        acc[k] += longint'(it.value) * longint'(iw_mem[it.row*UNITS + k]);
                        if (acc[k] > acc_hi)
                            acc[k] = acc_hi;
                        if (acc[k] < -acc_hi - 1)
                            acc[k] = -acc_hi - 1;
                    end
                if (it.step_last)
                begin
                    for (int k = 0; k < nu; k++)
                    begin
                        s = acc[k];
                        if (bias_sel == BIAS_SINGLE)
                            s += longint'(bias1[k]) * 4096;
                        else if (bias_sel == BIAS_DUAL)
                            s += (longint'(bias1[k]) + longint'(bias2[k])) * 4096;
                        if (!it.seq_start)
                            for (int j = 0; j < nu; j++)
                                s += longint'(prev_h[j]) * longint'(rw_mem[j*UNITS + k]);
                        s = (s + 2048) >>> 12;
                        if (s > 32767)
                            s = 32767;
                        if (s < -32768)
                            s = -32768;
                        idx = int'(((s + 32768) * TANH_ENTRIES) >>> 16);
                        fresh[k] = tanh_lut[idx];
                    end
                    for (int k = 0; k < UNITS; k++)
                        acc[k] = 0;
                    for (int k = 0; k < nu; k++)
                        prev_h[k] = fresh[k];
                    if (ret_all || it.seq_last)
                        for (int k = 0; k < nu; k++)
                        begin
                            h.unit_index   = 6'(k);
                            h.hidden_value = fresh[k];
                            h.last         = (k == nu - 1);
                            hidden_q.push_back(h);
                        end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(item_t it);
        mode      <= it.mode;
        row       <= it.row;
        column    <= it.column;
        value     <= it.value;
        seq_start <= it.seq_start;
        step_last <= it.step_last;
        seq_last  <= it.seq_last;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_cell(it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (hidden_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [6:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_RET_ALL:  ret_all   = data[0];
            CFG_BIAS:     bias_sel  = data[1:0];
            CFG_UNITS:    units_cfg = data;
            CFG_FEATURES: feats_cfg = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic r, logic [1:0] b, logic [6:0] nu, logic [6:0] nf);
        settle();
        write_reg(CFG_RET_ALL, {6'd0, r});
        write_reg(CFG_BIAS, {5'd0, b});
        write_reg(CFG_UNITS, nu);
        write_reg(CFG_FEATURES, nf);
    endtask

    function automatic logic signed [15:0] rand_value();
        if ($urandom_range(0, 2) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 1023)) - 512);
    endfunction

    function automatic item_t make_item(logic [2:0] md, int r, int c, logic signed [15:0] v,
                                        bit ss, bit sl, bit sq);
        item_t it;
        it.mode = md;
        it.row = 6'(r);
        it.column = 6'(c);
        it.value = v;
        it.seq_start = ss;
        it.step_last = sl;
        it.seq_last = sq;
        return it;
    endfunction

    // only the first LOAD_N rows and columns of each store are loaded, so
    // sampled rows stay below LOAD_N or at or above the feature count
    task automatic random_sequences(int n_items);
        int    nf;
        int    rows;
        int    steps;
        int    samples;
        int    sent;
        int    r;
        item_t it;
        nf = eff_count(feats_cfg, FEATURES);
        rows = (nf < LOAD_N) ? nf : LOAD_N;
        sent = 0;
        while (sent < n_items)
        begin
            steps = $urandom_range(1, 3);
            for (int s = 0; s < steps; s++)
            begin
                samples = $urandom_range(1, (nf < 6) ? nf + 1 : 6);
                for (int k = 0; k < samples; k++)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        it = make_item(3'($urandom_range(0, 3)), $urandom_range(0, 63),
                                       $urandom_range(0, 63), rand_value(),
                                       1'($urandom), 1'($urandom), 1'($urandom));
                    else if (r == 1)
                        it = make_item(3'($urandom_range(MODE_SPARE, 7)), $urandom,
                                       $urandom, 16'($urandom), 1'($urandom), 1'($urandom),
                                       1'($urandom));
                    else
                        it = make_item(MODE_FEAT,
                                       ($urandom_range(0, 7) == 0) ? $urandom_range(nf, 63)
                                                                   : $urandom_range(0, rows - 1),
                                       $urandom_range(0, 63), rand_value(),
                                       s == 0, k == samples - 1, s == steps - 1);
                    send_item(it);
                    if (it.mode <= MODE_FEAT)
                        sent++;
                end
            end
        end
        rand_items += sent;
    endtask

    // result check and watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (hidden_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: unit %0d hidden %0d last %0b",
                             unit_index, hidden_value, last);
            end
            else
            begin
                if (unit_index !== hidden_q[0].unit_index
                    || hidden_value !== hidden_q[0].hidden_value
                    || last !== hidden_q[0].last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp unit %0d hidden %0d last %0b, got %0d %0d %0b",
                                 hidden_q[0].unit_index, hidden_q[0].hidden_value,
                                 hidden_q[0].last, unit_index, hidden_value, last);
                end
                void'(hidden_q.pop_front());
            end
        end
    end

    // receiver stall bursts
    int  stall_left;
    bit  stall_on;
    always @(posedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_on   = ($urandom_range(0, 2) == 0);
                stall_left = $urandom_range(1, 16);
            end
            stall_left--;
            out_stall <= stall_on;
        end
    end

    stim_row_t directed [$];
    int        q_before;

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RET_ALL;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = MODE_FEAT;
        row = '0;
        column = '0;
        value = '0;
        seq_start = 1'b0;
        step_last = 1'b0;
        seq_last = 1'b0;
        out_stall = 1'b0;
        stall_left = 0;
        stall_on = 0;
        quiet = 0;
        mismatches = 0;
        idle_cycles = 0;
        rand_items = 0;
        ret_all = 1'b0;
        bias_sel = BIAS_SINGLE;
        units_cfg = 7'd16;
        feats_cfg = 7'd16;
        for (int k = 0; k < UNITS; k++)
        begin
            acc[k] = 0;
            prev_h[k] = '0;
        end
        fill_tanh_lut();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every store entry that a later item reads
        for (int f = 0; f < LOAD_N; f++)
            for (int u = 0; u < LOAD_N; u++)
                send_item(make_item(MODE_IW, f, u, rand_value(), 1, 1, 1));
        for (int f = 0; f < LOAD_N; f++)
            for (int u = 0; u < LOAD_N; u++)
                send_item(make_item(MODE_RW, f, u, rand_value(), 1, 1, 1));
        for (int u = 0; u < LOAD_N; u++)
        begin
            send_item(make_item(MODE_B1, 0, u, rand_value(), 1, 1, 1));
            send_item(make_item(MODE_B2, 0, u, rand_value(), 1, 1, 1));
        end

        // directed: zero input with no bias gives tanh of the center bin
        set_regs(1'b0, BIAS_NONE, 7'(LOAD_N), 7'd16);
        directed = '{
            '{make_item(MODE_IW, 63, 0, 16'sh7fff, 1, 1, 1), 0, 0},
            '{make_item(MODE_IW, 0, 63, 16'sh7fff, 1, 1, 1), 0, 0},
            '{make_item(MODE_RW, 0, 63, 16'sh8000, 1, 1, 1), 0, 0},
            '{make_item(MODE_RW, 40, 1, 16'sh8000, 1, 1, 1), 0, 0},
            '{make_item(MODE_B1, 0, 63, 16'sh7fff, 1, 1, 1), 0, 0},
            '{make_item(MODE_B2, 0, 40, 16'sh8000, 1, 1, 1), 0, 0},
            '{make_item(MODE_SPARE, 0, 0, 16'sh7fff, 1, 1, 1), 0, 0},
            '{make_item(3'd6, 63, 63, 16'sh8000, 1, 1, 1), 0, 0},
            '{make_item(3'd7, 21, 42, 16'sh5555, 1, 1, 1), 0, 0},
            '{make_item(MODE_FEAT, 0, 0, 16'sh0000, 1, 1, 1), 1, 32},
            '{make_item(MODE_FEAT, 20, 0, 16'sh8000, 1, 1, 1), 1, 32},
            '{make_item(MODE_FEAT, 0, 0, 16'sh7fff, 1, 0, 0), 0, 0},
            '{make_item(MODE_FEAT, 3, 63, 16'sh8000, 1, 0, 0), 0, 0},
            '{make_item(MODE_FEAT, 3, 0, 16'sh0100, 1, 1, 0), 0, 0},
            '{make_item(MODE_FEAT, 1, 0, 16'sh0001, 0, 1, 1), 0, 0},
            '{make_item(MODE_IW, 15, 15, 16'sh8000, 0, 0, 0), 0, 0},
            '{make_item(MODE_RW, 15, 15, 16'sh7fff, 0, 0, 0), 0, 0},
            '{make_item(MODE_B1, 0, 15, 16'sh7fff, 0, 0, 0), 0, 0},
            '{make_item(MODE_B2, 0, 0, 16'shffff, 0, 0, 0), 0, 0},
            '{make_item(MODE_FEAT, 2, 0, 16'sh7fff, 0, 0, 0), 0, 0},
            '{make_item(MODE_FEAT, 63, 0, 16'sh0040, 0, 1, 1), 0, 0}
        };
        foreach (directed[i])
        begin
            q_before = hidden_q.size();
            send_item(directed[i].it);
            if (directed[i].typed)
                for (int k = q_before; k < hidden_q.size(); k++)
                    hidden_q[k].hidden_value = 16'(directed[i].hidden);
        end

        set_regs(1'b1, BIAS_SINGLE, 7'd4, 7'd4);
        random_sequences(20);
        set_regs(1'b0, BIAS_DUAL, 7'd1, 7'd1);
        random_sequences(15);
        set_regs(1'b1, 2'd3, 7'd4, 7'd64);
        random_sequences(20);
        set_regs(1'b1, BIAS_NONE, 7'd0, 7'd0);
        random_sequences(15);
        set_regs(1'b0, BIAS_DUAL, 7'd3, 7'd5);
        random_sequences(20);
        set_regs(1'b1, BIAS_SINGLE, 7'd2, 7'd127);
        random_sequences(15);
        set_regs(1'b1, BIAS_DUAL, 7'd4, 7'd16);
        quiet = 1;
        random_sequences(15);

        in_valid <= 1'b0;
        while (hidden_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && hidden_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
